// ===== rtl/core/vll_pkg.sv =====
// Shared types and constants for the vector length limiter.
// No dependencies; every other file in rtl/core but vll_checker.sv imports this package.
package vll_pkg;

   localparam int unsigned CompW  = 32;
   localparam int unsigned LimW   = 31;
   localparam int unsigned SumW   = 64;
   localparam int unsigned RootW  = 32;
   localparam int unsigned ProdW  = CompW + LimW;
   localparam int unsigned QuotW  = LimW;
   localparam int unsigned Lanes  = 3;
   localparam int unsigned SqrtSteps = SumW / 2;

   // Per-request values that ride along the pipeline beside the math.
   typedef struct packed {
      logic [Lanes-1:0][CompW-1:0] mag;
      logic [Lanes-1:0]            neg;
      logic [LimW-1:0]             lim;
      logic                        clamp;
   } vll_side_type;

endpackage

// ===== rtl/core/vll_sqr.sv =====
// Front end: component magnitudes, squares, sum and compare with limit squared.
// Three register stages; depends on vll_pkg.
module vll_sqr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [2:0][vll_pkg::CompW-1:0]    in_vec,
   input  logic [vll_pkg::LimW-1:0]          in_lim,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [vll_pkg::SumW-1:0]          out_sum,
   output vll_pkg::vll_side_type             out_side
);
   import vll_pkg::*;

   logic                    va_ff, vb_ff, vc_ff;
   logic                    en_a, en_b, en_c;
   vll_side_type            side_a_ff, side_b_ff, side_c_ff;
   vll_side_type            side_a_in, side_c_in;
   logic [Lanes-1:0][SumW-1:0] sq_b_ff;
   logic [2*LimW-1:0]       lsq_b_ff;
   logic [SumW-1:0]         sum_c_ff, sum_c_in;

   assign en_c     = !vc_ff || out_ready;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      side_a_in = '0;
      for (int l = 0; l < Lanes; l++) begin
         side_a_in.neg[l] = in_vec[l][CompW-1];
         side_a_in.mag[l] = in_vec[l][CompW-1] ? CompW'(-in_vec[l]) : in_vec[l];
      end
      side_a_in.lim = in_lim;
   end

   always_comb begin
      sum_c_in = sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
      side_c_in = side_b_ff;
      side_c_in.clamp = sum_c_in > SumW'(lsq_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= in_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) side_a_ff <= side_a_in;
      if (en_b) begin
         side_b_ff <= side_a_ff;
         for (int l = 0; l < Lanes; l++) begin
            sq_b_ff[l] <= SumW'(side_a_ff.mag[l]) * SumW'(side_a_ff.mag[l]);
         end
         lsq_b_ff <= (2*LimW)'(side_a_ff.lim) * (2*LimW)'(side_a_ff.lim);
      end
      if (en_c) begin
         side_c_ff <= side_c_in;
         sum_c_ff  <= sum_c_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_sum   = sum_c_ff;
   assign out_side  = side_c_ff;

endmodule

// ===== rtl/core/vll_isqrt.sv =====
// Pipelined floor square root of the 64-bit sum of squares, one result bit
// per stage. Depends on vll_pkg.
module vll_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [vll_pkg::SumW-1:0]          in_sum,
   input  vll_pkg::vll_side_type             in_side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [vll_pkg::RootW-1:0]         out_root,
   output vll_pkg::vll_side_type             out_side
);
   import vll_pkg::*;

   logic [SqrtSteps-1:0] v_ff;
   logic [SqrtSteps:0]   en;
   logic [SumW-1:0]      n_ff   [SqrtSteps];
   logic [SumW-1:0]      res_ff [SqrtSteps];
   vll_side_type         side_ff [SqrtSteps];

   assign en[SqrtSteps] = out_ready;
   assign in_ready      = en[0];

   for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
      localparam logic [SumW-1:0] Bit = SumW'(1) << (SumW - 2 - 2*s);
      logic [SumW-1:0] n_prev, res_prev, n_in, res_in, trial;
      logic            v_prev;
      vll_side_type    side_prev;

      if (s == 0) begin : g_first
         assign n_prev    = in_sum;
         assign res_prev  = '0;
         assign v_prev    = in_valid;
         assign side_prev = in_side;
      end else begin : g_next
         assign n_prev    = n_ff[s-1];
         assign res_prev  = res_ff[s-1];
         assign v_prev    = v_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign en[s] = !v_ff[s] || en[s+1];

      always_comb begin
         trial = res_prev + Bit;
         if (n_prev >= trial) begin
            n_in   = n_prev - trial;
            res_in = (res_prev >> 1) + Bit;
         end else begin
            n_in   = n_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            n_ff[s]    <= n_in;
            res_ff[s]  <= res_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[SqrtSteps-1];
   assign out_root  = res_ff[SqrtSteps-1][RootW-1:0];
   assign out_side  = side_ff[SqrtSteps-1];

endmodule

// ===== rtl/core/vll_div.sv =====
// Scaling: products of magnitude and limit, then a restoring divide by the
// root, one quotient bit per stage in three lanes. Depends on vll_pkg.
module vll_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [vll_pkg::RootW-1:0]         in_root,
   input  vll_pkg::vll_side_type             in_side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [2:0][vll_pkg::QuotW-1:0]    out_quot,
   output vll_pkg::vll_side_type             out_side
);
   import vll_pkg::*;

   localparam int unsigned Stages = QuotW + 1;

   logic [Stages-1:0]           v_ff;
   logic [Stages:0]             en;
   logic [Lanes-1:0][ProdW-1:0] rem_ff  [Stages];
   logic [Lanes-1:0][QuotW-1:0] quot_ff [Stages];
   logic [RootW-1:0]            den_ff  [Stages];
   vll_side_type                side_ff [Stages];

   assign en[Stages] = out_ready;
   assign in_ready   = en[0];

   assign en[0] = !v_ff[0] || en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int l = 0; l < Lanes; l++) begin
            rem_ff[0][l] <= ProdW'(in_side.mag[l]) * ProdW'(in_side.lim);
         end
         quot_ff[0] <= '0;
         den_ff[0]  <= in_root;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 1; s < Stages; s++) begin : g_step
      localparam int unsigned Shift = QuotW - s;
      logic [ProdW-1:0]            dsh;
      logic [Lanes-1:0][ProdW-1:0] rem_in;
      logic [Lanes-1:0][QuotW-1:0] quot_in;

      assign en[s] = !v_ff[s] || en[s+1];
      assign dsh   = ProdW'(den_ff[s-1]) << Shift;

      always_comb begin
         rem_in  = rem_ff[s-1];
         quot_in = quot_ff[s-1];
         for (int l = 0; l < Lanes; l++) begin
            if (rem_ff[s-1][l] >= dsh) begin
               rem_in[l]         = rem_ff[s-1][l] - dsh;
               quot_in[l][Shift] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in;
            quot_ff[s] <= quot_in;
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign out_quot  = quot_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

endmodule

// ===== rtl/core/vector_length_limiter_core.sv =====
// Clamps a signed Q16.16 three-component vector to a maximum length. One
// request enters per clock while the pipeline is not stalled. A request passes
// through 3 stages for squares and the compare, 32 for the square root (one
// root bit each), 1 for the scaling products and 31 for the divide (one
// quotient bit each), plus the output register. Every stage advances on its own,
// so bubbles close up while the result side is stalled and requests keep coming
// in until the pipeline is full. Vectors no longer than the limit pass through
// unchanged with the flag clear; longer ones are scaled to the limit,
// truncated toward zero, with the flag set. Fixed point scale cancels out.
module vector_length_limiter_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // vec_x, vec_y, vec_z, limit[30:0], 1'b0
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,  // out_x, out_y, out_z
   output logic [0:0]    rsp_tuser   // was_clamped
);
   import vll_pkg::*;

   logic                       sq_valid, sq_ready, rt_valid, rt_ready, dv_valid;
   logic [SumW-1:0]            sq_sum;
   vll_side_type               sq_side, rt_side, dv_side;
   logic [RootW-1:0]           rt_root;
   logic [Lanes-1:0][QuotW-1:0] dv_quot;
   logic [2:0][CompW-1:0]      req_vec;
   logic                       en_out;
   logic [Lanes-1:0][CompW-1:0] out_in;
   logic [Lanes-1:0][CompW-1:0] out_ff;
   logic                       flag_ff, valid_ff;

   assign req_vec[0] = req_tdata[31:0];
   assign req_vec[1] = req_tdata[63:32];
   assign req_vec[2] = req_tdata[95:64];

   vll_sqr u_sqr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_vec    (req_vec),
      .in_lim    (req_tdata[126:96]),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_sum   (sq_sum),
      .out_side  (sq_side)
   );

   vll_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_sum    (sq_sum),
      .in_side   (sq_side),
      .out_valid (rt_valid),
      .out_ready (rt_ready),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   vll_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_ready  (rt_ready),
      .in_root   (rt_root),
      .in_side   (rt_side),
      .out_valid (dv_valid),
      .out_ready (en_out),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   assign en_out = !valid_ff || rsp_tready;

   // Pick quotient or original magnitude, then restore the sign.
   always_comb begin
      logic [CompW-1:0] val;
      for (int l = 0; l < Lanes; l++) begin
         val = dv_side.clamp ? CompW'(dv_quot[l]) : dv_side.mag[l];
         out_in[l] = dv_side.neg[l] ? CompW'(-val) : val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en_out) begin
         valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_ff  <= out_in;
         flag_ff <= dv_side.clamp;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = {out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tuser[0] = flag_ff;

endmodule

// ===== rtl/core/vll_checker.sv =====
// Port-level checks for vector_length_limiter_core, bound to the top level.
// No package dependencies.
module vll_port_props (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [95:0]   rsp_tdata,
   input logic [0:0]    rsp_tuser
);

   // Empty output side means the whole pipeline can advance.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while output is empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind vector_length_limiter_core vll_port_props u_vll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
